// ===== hdl/mmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and codes of the fixed point matrix multiplier
// action codes, the queued command and the size registers
// ----------------------------------------------------------------------------
package mmf_pkg;

   localparam logic [1:0] ACT_WRITE_A = 2'd0;
   localparam logic [1:0] ACT_WRITE_B = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROWS_A     = 2'd0;
   localparam logic [1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [1:0] CSR_COLS_B     = 2'd2;

   localparam int SIZE_W     = 4;
   localparam int INDEX_W    = 3;
   localparam int ELEM_W     = 16;
   localparam int RESULT_W   = 40;
   localparam int ELEM_EXT_W = 32;
   localparam int PROD_EXT_W = 64;

   typedef struct packed {
      logic [1:0]               action;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [ELEM_W-1:0] elem;
   } cmd_type;

   typedef struct packed {
      logic [SIZE_W-1:0] rows_a;
      logic [SIZE_W-1:0] inner_size;
      logic [SIZE_W-1:0] cols_b;
   } size_cfg_type;

endpackage

// ===== hdl/mmf_ram.sv =====
// ----------------------------------------------------------------------------
// mmf_ram: generic single write, single read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module mmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmf_front.sv =====
// ----------------------------------------------------------------------------
// mmf_front: input side of the matrix multiplier
// accepts items, drops unused codes and out of range writes, and queues the
// rest in a two entry queue for the compute engine
// ----------------------------------------------------------------------------
module mmf_front
   import mmf_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [INDEX_W-1:0]       req_row_index,
   input  logic [INDEX_W-1:0]       req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push;
   logic       pop;
   logic       in_range;

   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);

   always_comb begin
      case (req_action)
         ACT_WRITE_A: keep = in_range;
         ACT_WRITE_B: keep = in_range;
         ACT_COMPUTE: keep = 1'b1;
         default:     keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && keep;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{action: req_action, row: req_row_index,
                              col: req_col_index, elem: req_element_value};
      end
   end

endmodule

// ===== hdl/mmf_back.sv =====
// ----------------------------------------------------------------------------
// mmf_back: compute engine of the matrix multiplier
// writes loaded elements into the A and B memories and runs the
// multiply-accumulate sequence for a product, one result element at a time
// ----------------------------------------------------------------------------
module mmf_back
   import mmf_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   input  size_cfg_type               size_cfg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_result_row,
   output logic [INDEX_W-1:0]         rsp_result_col,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic                       rsp_last
);

   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int PW = 2 * DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   function automatic logic [IW-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [IW-1:0] idx;
      if (size == '0) begin
         idx = '0;
      end else if (32'(size) > MAX_DIM) begin
         idx = IW'(MAX_DIM - 1);
      end else begin
         idx = IW'(size - 4'd1);
      end
      return idx;
   endfunction

   state_type state_ff, state_in;
   logic [IW-1:0] r_ff, r_in;
   logic [IW-1:0] c_ff, c_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] nr_last_ff, nr_last_in;
   logic [IW-1:0] nk_last_ff, nk_last_in;
   logic [IW-1:0] nc_last_ff, nc_last_in;

   logic s1_vld_ff, s1_first_ff, s1_last_ff;
   logic s2_vld_ff, s2_first_ff, s2_last_ff;
   logic signed [PW-1:0] s2_prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [PROD_EXT_W-1:0] prod_ext;
   logic [RESULT_W-1:0] acc_ff, acc_in;
   logic out_vld_ff, out_vld_in;

   logic issuing;
   logic busy;
   logic elem_last;
   logic proceed;
   logic signed [ELEM_EXT_W-1:0] elem_ext;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] a_data;
   logic [DATA_WIDTH-1:0] b_data;
   logic wr_en_a;
   logic wr_en_b;

   // store side
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign elem_ext = ELEM_EXT_W'(cmd.elem);
   assign wr_data  = elem_ext[DATA_WIDTH-1:0];
   assign wr_addr  = AW'(32'(cmd.row) * MAX_DIM + 32'(cmd.col));
   assign wr_en_a  = cmd_pop && (cmd.action == ACT_WRITE_A);
   assign wr_en_b  = cmd_pop && (cmd.action == ACT_WRITE_B);

   assign rd_addr_a = AW'(32'(r_ff) * MAX_DIM + 32'(j_ff));
   assign rd_addr_b = AW'(32'(j_ff) * MAX_DIM + 32'(c_ff));

   mmf_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   mmf_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   // sequencer
   assign issuing   = (state_ff == ST_ISSUE);
   assign busy      = s1_vld_ff || s2_vld_ff;
   assign elem_last = (r_ff == nr_last_ff) && (c_ff == nc_last_ff);
   assign proceed   = !busy && (!out_vld_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      j_in       = j_ff;
      nr_last_in = nr_last_ff;
      nk_last_in = nk_last_ff;
      nc_last_in = nc_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && (cmd.action == ACT_COMPUTE)) begin
               nr_last_in = last_index(size_cfg.rows_a);
               nk_last_in = last_index(size_cfg.inner_size);
               nc_last_in = last_index(size_cfg.cols_b);
               r_in       = '0;
               c_in       = '0;
               j_in       = '0;
               state_in   = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (j_ff == nk_last_ff) begin
               j_in     = '0;
               state_in = ST_WAIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (proceed) begin
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (c_ff == nc_last_ff) begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // multiply and accumulate
   assign prod_in  = $signed(a_data) * $signed(b_data);
   assign prod_ext = PROD_EXT_W'(s2_prod_ff);

   always_comb begin
      acc_in     = acc_ff;
      out_vld_in = out_vld_ff;
      if (rsp_valid && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (s2_vld_ff) begin
         acc_in = s2_first_ff ? prod_ext[RESULT_W-1:0] : acc_ff + prod_ext[RESULT_W-1:0];
         if (s2_last_ff) begin
            out_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         s1_vld_ff  <= issuing;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      c_ff        <= c_in;
      j_ff        <= j_in;
      nr_last_ff  <= nr_last_in;
      nk_last_ff  <= nk_last_in;
      nc_last_ff  <= nc_last_in;
      s1_first_ff <= (j_ff == '0);
      s1_last_ff  <= (j_ff == nk_last_ff);
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_prod_ff  <= prod_in;
      acc_ff      <= acc_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_row   = INDEX_W'(r_ff);
   assign rsp_result_col   = INDEX_W'(c_ff);
   assign rsp_result_value = $signed(acc_ff);
   assign rsp_last         = elem_last;

   // a finished sum never lands on a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff && s2_last_ff |-> !out_vld_ff)
      else $error("result register overwritten");

   // loads cannot reach the memories while a product is in flight
   a_pipe_not_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> state_ff != ST_IDLE)
      else $error("pipeline busy while idle");

   a_inner_bound: assert property (@(posedge clock) disable iff (reset)
      issuing |-> j_ff <= nk_last_ff)
      else $error("inner index past size");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> state_ff == ST_IDLE)
      else $error("product continues after last transfer");

endmodule

// ===== hdl/matrix_multiply_fixed.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_fixed: dense fixed point matrix multiply
// Q4.12 elements of A and B are loaded one per transfer; a compute transfer
// streams the Q16.24 product elements in row-major order.
//
// req channel: action 0 writes A[row][col], 1 writes B[row][col], 2 computes.
// Loads stream back to back through a two entry queue. A compute transfer
// blocks later items in the queue until its last result transfer. Each
// result element is built by the single shared multiply-accumulate path
// (memory read, multiply, accumulate), one element at a time.
// rsp channel: one result per transfer, last marks the final element; a
// stalled result holds in the output register and the engine waits for it.
// csr port: rows_a, inner_size and cols_b, written while no product is
// pending; a size of zero acts as one, above MAX_DIM as MAX_DIM.
// Reset sets all sizes to 8 and empties the queue; the memories are not
// cleared and read as unknown until written.
// ----------------------------------------------------------------------------
module matrix_multiply_fixed
   import mmf_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic [INDEX_W-1:0]         req_row_index,
   input  logic [INDEX_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0]   req_element_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_result_row,
   output logic [INDEX_W-1:0]         rsp_result_col,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic                       rsp_last,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [SIZE_W-1:0]          csr_write_data
);

   size_cfg_type size_cfg_ff, size_cfg_in;
   cmd_type      cmd;
   logic         cmd_valid;
   logic         cmd_pop;

   always_comb begin
      size_cfg_in = size_cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS_A:     size_cfg_in.rows_a     = csr_write_data;
            CSR_INNER_SIZE: size_cfg_in.inner_size = csr_write_data;
            CSR_COLS_B:     size_cfg_in.cols_b     = csr_write_data;
            default:        size_cfg_in = size_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff <= '{rows_a: 4'd8, inner_size: 4'd8, cols_b: 4'd8};
      end else begin
         size_cfg_ff <= size_cfg_in;
      end
   end

   mmf_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   mmf_back #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .size_cfg         (size_cfg_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last)
   );

endmodule
